// ===== sv/yuyv_to_rgb_decimate_overlay_macros.svh =====
// ----------------------------------------------------------------------------
// yuyv_to_rgb_decimate_overlay_macros.svh
// Assertion helpers for the checker of the YUYV converter.
// ----------------------------------------------------------------------------
`ifndef YUYV_TO_RGB_DECIMATE_OVERLAY_MACROS_SVH
`define YUYV_TO_RGB_DECIMATE_OVERLAY_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define YRDO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define YRDO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is checked through reset as well.
`define YRDO_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/yrdo_pkg.sv =====
// ----------------------------------------------------------------------------
// yrdo_pkg
// Shared constants, codes and helpers for the YUYV to RGB converter.
// ----------------------------------------------------------------------------
package yrdo_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam int CFG_DATA_W = 11;

    // Default parameter values
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_WINDOW_HALF = 80;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 11'd720;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 11'd480;

    // Distance from the center line to the sample line, and from the sample line to each marker line
    localparam int MARK_OFFSET = 2;

    // Overlay applied to a pixel
    typedef enum logic [2:0] {
        PAINT_NONE = 3'b001,
        PAINT_BLUE = 3'b010,
        PAINT_CYAN = 3'b100
    } paint_t;

    // floor(v / 256) clipped to 0..255
    function automatic logic [7:0] clip_shift(input logic signed [20:0] v);
        logic signed [12:0] t;
        logic [7:0]         res;
        t = v[20:8];
        if (t < 13'sd0) begin
            res = 8'd0;
        end else if (t > 13'sd255) begin
            res = 8'd255;
        end else begin
            res = t[7:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/yuyv_to_rgb_decimate_overlay.sv =====
// ----------------------------------------------------------------------------
// yuyv_to_rgb_decimate_overlay
// YUYV word to RGB conversion with line decimation and a centered overlay.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one packed YUYV beat per transfer (two source pixels) and a
//   frame_start flag that clears the column, line and sample counters.
//   m_ channel: one RGB beat per word on an even source line, with its
//   decimated row/column, the intensity sample on the measurement line and
//   an end-of-frame flag. Words on odd lines are consumed without output.
//   cfg_ port: frame width and height, to be written only while the block is idle (not enforced).
// Timing:
//   Three register stages: input capture (counters, window decode), color
//   conversion, then averaging and overlay. A result is offered on m_ once
//   it has passed all three; one beat per cycle is sustained, since every
//   stage loads on each cycle the output moves.
// Reset and stalls:
//   aresetn low clears counters, stage valids and restores the default
//   frame size. When m_ready is low the stages that hold data freeze and
//   s_ready drops once every stage is full; empty stages still fill.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_decimate_overlay #(
    parameter int MAX_WIDTH   = yrdo_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = yrdo_pkg::DEF_MAX_HEIGHT,
    parameter int WINDOW_HALF = yrdo_pkg::DEF_WINDOW_HALF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [yrdo_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [yrdo_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input beats
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [31:0]                         s_yuyv_word,
    input  logic                                s_frame_start,
    // result beats
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_red,
    output logic [7:0]                          m_green,
    output logic [7:0]                          m_blue,
    output logic [8:0]                          m_out_row,
    output logic [8:0]                          m_out_col,
    output logic                                m_sample_valid,
    output logic [6:0]                          m_sample_index,
    output logic [7:0]                          m_sample_value,
    output logic                                m_last_of_frame
);

    // Size clamps and window constants
    localparam logic [10:0] MAX_W_EFF =
        (MAX_WIDTH >= 2046) ? 11'd2046 : 11'(MAX_WIDTH - (MAX_WIDTH % 2));
    localparam logic [10:0] MAX_H_EFF =
        (MAX_HEIGHT >= 2046) ? 11'd2046 : 11'(MAX_HEIGHT - (MAX_HEIGHT % 2));
    localparam logic [11:0] WIN_HALF = 12'(WINDOW_HALF);
    localparam logic [6:0]  MARK_IDX = 7'((WINDOW_HALF - 1) % 128);
    localparam logic [10:0] MARK_OFS = 11'(yrdo_pkg::MARK_OFFSET);

    // ------------------------------------------------------------------
    // Configuration registers
    logic [10:0] frame_width_reg;
    logic [10:0] frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= yrdo_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= yrdo_pkg::RST_FRAME_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                yrdo_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                yrdo_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective even sizes, clamped to 2..max
    logic [10:0] w_eff;
    logic [10:0] h_eff;

    always_comb begin
        w_eff = {frame_width_reg[10:1], 1'b0};
        if (w_eff < 11'd2) w_eff = 11'd2;
        if (w_eff > MAX_W_EFF) w_eff = MAX_W_EFF;
        h_eff = {frame_height_reg[10:1], 1'b0};
        if (h_eff < 11'd2) h_eff = 11'd2;
        if (h_eff > MAX_H_EFF) h_eff = MAX_H_EFF;
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or its data moves on
    logic s1_valid_reg, s2_valid_reg;
    logic ld3, ld2, ld1;

    assign ld3     = !m_valid || m_ready;
    assign ld2     = !s2_valid_reg || ld3;
    assign ld1     = !s1_valid_reg || ld2;
    assign s_ready = ld1;

    logic accept;
    assign accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Stage 1: counters and window decode on the accepted beat
    logic [8:0]  word_column_reg, word_column_next;
    logic [9:0]  source_line_reg, source_line_next;
    logic [6:0]  sample_count_reg, sample_count_next;

    logic [8:0]  col;
    logic [9:0]  line;
    logic [6:0]  cnt;
    logic [9:0]  half_w;
    logic [9:0]  half_h;
    logic [11:0] x_pos;
    logic        in_win;
    logic        on_meas, on_upper, on_lower;
    logic        keep;
    logic [6:0]  cnt_inc;
    logic        is_last;
    yrdo_pkg::paint_t paint;

    always_comb begin
        col      = s_frame_start ? 9'd0  : word_column_reg;
        line     = s_frame_start ? 10'd0 : source_line_reg;
        cnt      = s_frame_start ? 7'd0  : sample_count_reg;
        half_w   = w_eff[10:1];
        half_h   = h_eff[10:1];
        x_pos    = {2'b00, col, 1'b0};
        in_win   = (x_pos + WIN_HALF > {2'b00, half_w}) &&
                   (x_pos < {2'b00, half_w} + WIN_HALF);
        keep     = !line[0];
        on_meas  = ({1'b0, line} == {1'b0, half_h} + MARK_OFS);
        on_upper = (line == half_h);
        on_lower = ({1'b0, line} == {1'b0, half_h} + (MARK_OFS << 1));
        cnt_inc  = cnt + 7'd1;
        is_last  = ({1'b0, line} == h_eff - 11'd2) &&
                   ({1'b0, col} == half_w - 10'd1);

        // overlay choice; the lower marker line wins
        paint = yrdo_pkg::PAINT_NONE;
        if (in_win && on_meas && (cnt_inc == 7'd1 || cnt_inc == MARK_IDX)) begin
            paint = yrdo_pkg::PAINT_BLUE;
        end
        if (in_win && on_upper) paint = yrdo_pkg::PAINT_BLUE;
        if (in_win && on_lower) paint = yrdo_pkg::PAINT_CYAN;

        // counter advance
        sample_count_next = (keep && in_win && on_meas) ? cnt_inc : cnt;
        if ({1'b0, col} + 10'd1 >= half_w) begin
            word_column_next = 9'd0;
            if ({1'b0, line} + 11'd1 >= h_eff) begin
                source_line_next  = 10'd0;
                sample_count_next = 7'd0;
            end else begin
                source_line_next = line + 10'd1;
            end
        end else begin
            word_column_next = col + 9'd1;
            source_line_next = line;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_column_reg  <= '0;
            source_line_reg  <= '0;
            sample_count_reg <= '0;
        end else if (accept) begin
            word_column_reg  <= word_column_next;
            source_line_reg  <= source_line_next;
            sample_count_reg <= sample_count_next;
        end
    end

    // Stage 1 registers
    logic [7:0]  s1_y_reg, s1_u_reg, s1_v_reg;
    logic [8:0]  s1_row_reg, s1_col_reg;
    logic        s1_samp_reg, s1_last_reg;
    logic [6:0]  s1_idx_reg;
    yrdo_pkg::paint_t s1_paint_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (ld1) begin
            s1_valid_reg <= accept && keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            s1_y_reg     <= s_yuyv_word[23:16];
            s1_u_reg     <= s_yuyv_word[15:8];
            s1_v_reg     <= s_yuyv_word[31:24];
            s1_row_reg   <= line[9:1];
            s1_col_reg   <= col;
            s1_samp_reg  <= in_win && on_meas;
            s1_idx_reg   <= (in_win && on_meas) ? cnt_inc : 7'd0;
            s1_last_reg  <= is_last;
            s1_paint_reg <= paint;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: BT.601 integer conversion and clipping
    logic signed [9:0]  c_term, d_term, e_term;
    logic signed [20:0] r_acc, g_acc, b_acc;
    logic [7:0]         r_clip, g_clip, b_clip;

    always_comb begin
        c_term = $signed({2'b00, s1_y_reg}) - 10'sd16;
        d_term = $signed({2'b00, s1_u_reg}) - 10'sd128;
        e_term = $signed({2'b00, s1_v_reg}) - 10'sd128;
        r_acc  = 21'(c_term) * 21'sd298 + 21'(e_term) * 21'sd409 + 21'sd128;
        g_acc  = 21'(c_term) * 21'sd298 - 21'(d_term) * 21'sd100
               - 21'(e_term) * 21'sd208 + 21'sd128;
        b_acc  = 21'(c_term) * 21'sd298 + 21'(d_term) * 21'sd516 + 21'sd128;
        r_clip = yrdo_pkg::clip_shift(r_acc);
        g_clip = yrdo_pkg::clip_shift(g_acc);
        b_clip = yrdo_pkg::clip_shift(b_acc);
    end

    logic [7:0]  s2_r_reg, s2_g_reg, s2_b_reg;
    logic [9:0]  s2_sum_reg;
    logic [8:0]  s2_row_reg, s2_col_reg;
    logic        s2_samp_reg, s2_last_reg;
    logic [6:0]  s2_idx_reg;
    yrdo_pkg::paint_t s2_paint_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (ld2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld2) begin
            s2_r_reg     <= r_clip;
            s2_g_reg     <= g_clip;
            s2_b_reg     <= b_clip;
            s2_sum_reg   <= {2'b00, r_clip} + {2'b00, g_clip} + {2'b00, b_clip};
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            s2_samp_reg  <= s1_samp_reg;
            s2_idx_reg   <= s1_idx_reg;
            s2_last_reg  <= s1_last_reg;
            s2_paint_reg <= s1_paint_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: intensity average and overlay
    // sum / 3 as (sum * 683) >> 11, exact for sums below 2048
    logic [19:0] avg_prod;
    logic [7:0]  avg;
    logic [7:0]  r_out, g_out, b_out;

    always_comb begin
        avg_prod = {10'd0, s2_sum_reg} * 20'd683;
        avg      = avg_prod[18:11];
        r_out    = s2_r_reg;
        g_out    = s2_g_reg;
        b_out    = s2_b_reg;
        unique case (s2_paint_reg)
            yrdo_pkg::PAINT_NONE: ;
            yrdo_pkg::PAINT_BLUE: begin
                r_out = 8'd0;
                g_out = 8'd0;
                b_out = 8'd255;
            end
            yrdo_pkg::PAINT_CYAN: begin
                r_out = 8'd0;
                g_out = 8'd255;
                b_out = 8'd255;
            end
            default: ;
        endcase
    end

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ld3) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld3) begin
            m_red           <= r_out;
            m_green         <= g_out;
            m_blue          <= b_out;
            m_out_row       <= s2_row_reg;
            m_out_col       <= s2_col_reg;
            m_sample_valid  <= s2_samp_reg;
            m_sample_index  <= s2_idx_reg;
            m_sample_value  <= s2_samp_reg ? avg : 8'd0;
            m_last_of_frame <= s2_last_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/yrdo_checker.sv =====
// ----------------------------------------------------------------------------
// yrdo_checker
// Port-level checks for the YUYV converter, bound onto the top level.
// ----------------------------------------------------------------------------
`include "yuyv_to_rgb_decimate_overlay_macros.svh"

module yrdo_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_red,
    input logic [7:0] m_green,
    input logic [7:0] m_blue,
    input logic       m_sample_valid,
    input logic [6:0] m_sample_index,
    input logic [7:0] m_sample_value
);

    // a stalled result beat stays offered
    `YRDO_ASSERT_NXT(a_hold_stall, aclk, aresetn, m_valid && !m_ready, m_valid)

    // reset empties the output stage
    `YRDO_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

    // sample fields are zero outside the measurement window
    `YRDO_ASSERT_IMP(a_nosample_zero, aclk, aresetn, m_valid && !m_sample_valid,
                     m_sample_index == 7'd0 && m_sample_value == 8'd0)

    // the first sample of the measurement line carries the blue marker
    `YRDO_ASSERT_IMP(a_first_marker, aclk, aresetn,
                     m_valid && m_sample_valid && m_sample_index == 7'd1,
                     m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd255)

endmodule

bind yuyv_to_rgb_decimate_overlay yrdo_checker u_yrdo_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_red          (m_red),
    .m_green        (m_green),
    .m_blue         (m_blue),
    .m_sample_valid (m_sample_valid),
    .m_sample_index (m_sample_index),
    .m_sample_value (m_sample_value)
);

// ===== sim/yrdo_checker.sv =====
// ----------------------------------------------------------------------------
// yrdo_scoreboard
// Scoreboard for the YUYV to RGB converter with line decimation and overlay.
// Snoops the size registers and both channels. For every accepted input beat
// it works out the RGB beat that should follow, if any. Each accepted result
// beat is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module yrdo_scoreboard (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [yrdo_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [yrdo_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [31:0]                     s_yuyv_word,
    input  logic                            s_frame_start,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [7:0]                      m_red,
    input  logic [7:0]                      m_green,
    input  logic [7:0]                      m_blue,
    input  logic [8:0]                      m_out_row,
    input  logic [8:0]                      m_out_col,
    input  logic                            m_sample_valid,
    input  logic [6:0]                      m_sample_index,
    input  logic [7:0]                      m_sample_value,
    input  logic                            m_last_of_frame,
    output int                              mismatch_count,
    output int                              pending_count,
    output int                              beats_checked,
    output int                              samples_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_HALF = yrdo_pkg::DEF_WINDOW_HALF;
    localparam int MAX_PRINTS = 100;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] row;
        logic [8:0] col;
        logic       smp_valid;
        logic [6:0] smp_index;
        logic [7:0] smp_value;
        logic       last;
    } rgb_beat_t;

    rgb_beat_t rgb_expected[$];

    // shadow of the size registers and the frame counters
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [8:0]  col_cnt;
    logic [9:0]  line_cnt;
    logic [6:0]  smp_cnt;

    initial begin
        mismatch_count  = 0;
        pending_count   = 0;
        beats_checked   = 0;
        samples_checked = 0;
    end

    // bit 0 dropped, then clamped to 2..cap
    function automatic int unsigned eff_size(input logic [10:0] r, input int unsigned cap);
        int unsigned s;
        s = {r[10:1], 1'b0};
        if (s < 2) s = 2;
        if (s > (cap & ~32'd1)) s = cap & ~32'd1;
        return s;
    endfunction

    // floor divide by 256, saturate to a byte
    function automatic int unsigned sat8(input int v);
        int t;
        t = v >>> 8;
        if (t < 0) return 0;
        if (t > 255) return 255;
        return t;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    // one input beat: update counters, queue the RGB beat for even lines
    task automatic convert_word(input logic [31:0] word, input logic fs);
        int unsigned w, h, words, half, x, meas, col, line;
        int unsigned r, g, b;
        int          c, d, e;
        logic        inwin;
        yrdo_pkg::paint_t paint;
        rgb_beat_t   beat;
        w     = eff_size(width_reg, yrdo_pkg::DEF_MAX_WIDTH);
        h     = eff_size(height_reg, yrdo_pkg::DEF_MAX_HEIGHT);
        words = w / 2;
        if (fs) begin
            col_cnt  = '0;
            line_cnt = '0;
            smp_cnt  = '0;
        end
        col  = col_cnt;
        line = line_cnt;

        if (line % 2 == 0) begin
            c = int'(word[23:16]) - 16;
            d = int'(word[15:8]) - 128;
            e = int'(word[31:24]) - 128;
            r = sat8(298 * c + 409 * e + 128);
            g = sat8(298 * c - 100 * d - 208 * e + 128);
            b = sat8(298 * c + 516 * d + 128);
            x     = 2 * col;
            half  = w / 2;
            inwin = (x + WIN_HALF > half) && (x < half + WIN_HALF);
            meas  = h / 2 + yrdo_pkg::MARK_OFFSET;
            paint = yrdo_pkg::PAINT_NONE;
            beat.smp_valid = 1'b0;
            beat.smp_index = '0;
            beat.smp_value = '0;

            // measurement line: sample before painting, end markers blue
            if (inwin && line == meas) begin
                smp_cnt        = smp_cnt + 7'd1;
                beat.smp_valid = 1'b1;
                beat.smp_index = smp_cnt;
                beat.smp_value = 8'((r + g + b) / 3);
                if (smp_cnt == 7'd1 || smp_cnt == 7'(WIN_HALF - 1))
                    paint = yrdo_pkg::PAINT_BLUE;
            end
            if (inwin && line == meas - yrdo_pkg::MARK_OFFSET) paint = yrdo_pkg::PAINT_BLUE;
            if (inwin && line == meas + yrdo_pkg::MARK_OFFSET) paint = yrdo_pkg::PAINT_CYAN;

            case (paint)
                yrdo_pkg::PAINT_BLUE: begin
                    r = 0;
                    g = 0;
                    b = 255;
                end
                yrdo_pkg::PAINT_CYAN: begin
                    r = 0;
                    g = 255;
                    b = 255;
                end
                default: ;
            endcase

            beat.red   = 8'(r);
            beat.green = 8'(g);
            beat.blue  = 8'(b);
            beat.row   = 9'(line / 2);
            beat.col   = 9'(col);
            beat.last  = (line == h - 2) && (col == words - 1);
            rgb_expected.push_back(beat);
        end

        // advance; counters past a shrunken limit wrap here too
        if (col + 1 >= words) begin
            col_cnt = '0;
            if (line + 1 >= h) begin
                line_cnt = '0;
                smp_cnt  = '0;
            end else begin
                line_cnt = 10'(line + 1);
            end
        end else begin
            col_cnt = 9'(col + 1);
        end
    endtask

    task automatic compare_beat(input rgb_beat_t want);
        if (m_red != want.red) report_mismatch("red", m_red, want.red);
        if (m_green != want.green) report_mismatch("green", m_green, want.green);
        if (m_blue != want.blue) report_mismatch("blue", m_blue, want.blue);
        if (m_out_row != want.row) report_mismatch("out_row", m_out_row, want.row);
        if (m_out_col != want.col) report_mismatch("out_col", m_out_col, want.col);
        if (m_sample_valid != want.smp_valid)
            report_mismatch("sample_valid", m_sample_valid, want.smp_valid);
        if (m_sample_index != want.smp_index)
            report_mismatch("sample_index", m_sample_index, want.smp_index);
        if (m_sample_value != want.smp_value)
            report_mismatch("sample_value", m_sample_value, want.smp_value);
        if (m_last_of_frame != want.last)
            report_mismatch("last_of_frame", m_last_of_frame, want.last);
    endtask

    // snoop on every rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = yrdo_pkg::RST_FRAME_WIDTH;
            height_reg = yrdo_pkg::RST_FRAME_HEIGHT;
            col_cnt    = '0;
            line_cnt   = '0;
            smp_cnt    = '0;
            rgb_expected.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    yrdo_pkg::CFG_FRAME_WIDTH:  width_reg  = cfg_wdata;
                    yrdo_pkg::CFG_FRAME_HEIGHT: height_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) convert_word(s_yuyv_word, s_frame_start);
            if (m_valid && m_ready) begin
                if (rgb_expected.size() == 0) begin
                    report_mismatch("unexpected beat at row/col", m_out_row, m_out_col);
                end else begin
                    compare_beat(rgb_expected.pop_front());
                    beats_checked++;
                    if (m_sample_valid) samples_checked++;
                end
            end
        end
        pending_count = rgb_expected.size();
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the YUYV to RGB converter.
// Drives packed YUYV beats with random gaps and result back-pressure over many
// frame sizes: small frames that reach the marker and sample lines, odd and
// out-of-range sizes, shrinking mid-frame and the largest sizes. The checker
// instance predicts and compares; this module only stimulates and decides.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int TARGET_ITEMS = 1650;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [yrdo_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [yrdo_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    logic [31:0]                     s_yuyv_word;
    logic                            s_frame_start;
    logic                            m_valid;
    logic                            m_ready;
    logic [7:0]                      m_red;
    logic [7:0]                      m_green;
    logic [7:0]                      m_blue;
    logic [8:0]                      m_out_row;
    logic [8:0]                      m_out_col;
    logic                            m_sample_valid;
    logic [6:0]                      m_sample_index;
    logic [7:0]                      m_sample_value;
    logic                            m_last_of_frame;

    int mismatch_count;
    int pending_count;
    int beats_checked;
    int samples_checked;

    // idle control shared by sender and receiver
    int tx_gap_max;
    int rx_gap_max;
    bit hold_req;
    bit hold_done;
    bit rx_hold;
    int items_sent;
    int settings_used;
    int stall_cycles;

    yuyv_to_rgb_decimate_overlay dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_yuyv_word     (s_yuyv_word),
        .s_frame_start   (s_frame_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_sample_valid  (m_sample_valid),
        .m_sample_index  (m_sample_index),
        .m_sample_value  (m_sample_value),
        .m_last_of_frame (m_last_of_frame)
    );

    yrdo_scoreboard u_scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_yuyv_word     (s_yuyv_word),
        .s_frame_start   (s_frame_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_sample_valid  (m_sample_valid),
        .m_sample_index  (m_sample_index),
        .m_sample_value  (m_sample_value),
        .m_last_of_frame (m_last_of_frame),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count),
        .beats_checked   (beats_checked),
        .samples_checked (samples_checked)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: too long without any beat on either channel
    initial begin
        stall_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results pending",
                         stall_cycles, pending_count);
                $display("FAIL yuyv_to_rgb_decimate_overlay");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                rx_hold   = 1'b1;
                m_ready  <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                rx_hold   = 1'b0;
            end
            gap = (rx_gap_max == 0) ? 0 : $urandom_range(rx_gap_max, 0);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    function automatic int pick_gap_max();
        case ($urandom_range(3, 0))
            0:       return 0;
            1:       return 3;
            default: return 18;
        endcase
    endfunction

    // bytes biased toward the conversion corners
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7, 0))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'd16;
            3:       return 8'd128;
            4:       return 8'd235;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        if ($urandom_range(2, 0) == 0) return $urandom;
        return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    endfunction

    // hand-picked beats: {V, Y, U, Y2}
    function automatic logic [31:0] directed_word(input int i);
        case (i)
            0:  return 32'h00000000;
            1:  return 32'hFFFFFFFF;
            2:  return 32'h80108010;   // black
            3:  return 32'h80EB80EB;   // white
            4:  return 32'hFF0000FF;   // V max, Y and U min
            5:  return 32'h00FFFF00;   // V min, Y and U max
            6:  return 32'h00FF0000;
            7:  return 32'hFF00FF00;
            8:  return 32'h80F08080;
            9:  return 32'h007FFF7F;
            10: return 32'hFF8000FF;
            11: return 32'h12345678;
            default: return i[0] ? 32'hAAAAAAAA : 32'h55555555;
        endcase
    endfunction

    function automatic logic [10:0] pick_width();
        int sel;
        sel = $urandom_range(19, 0);
        if (sel < 14) return 11'($urandom_range(40, 0));
        if (sel < 17) return 11'($urandom_range(170, 150));
        if (sel < 19) begin
            case ($urandom_range(5, 0))
                0:       return 11'd0;
                1:       return 11'd1;
                2:       return 11'd2;
                3:       return 11'd1024;
                4:       return 11'd1025;
                default: return 11'd2047;
            endcase
        end
        return 11'($urandom);
    endfunction

    function automatic logic [10:0] pick_height();
        int sel;
        sel = $urandom_range(19, 0);
        if (sel < 16) return 11'($urandom_range(24, 0));
        case ($urandom_range(4, 0))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd1024;
            3:       return 11'd2047;
            default: return 11'($urandom);
        endcase
    endfunction

    // stop offering and wait until the block has nothing left in flight
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_sizes(input logic [10:0] w, input logic [10:0] h);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= yrdo_pkg::CFG_FRAME_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_addr  <= yrdo_pkg::CFG_FRAME_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
        tx_gap_max = pick_gap_max();
        rx_gap_max = pick_gap_max();
    endtask

    // one input beat, held until taken
    task automatic send_word(input logic [31:0] word, input logic fs);
        int gap;
        gap = (rx_hold || tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_yuyv_word   <= word;
        s_frame_start <= fs;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic run_frames(input int n, input bit fs_first, input int fs_pct);
        int  i;
        logic fs;
        for (i = 0; i < n; i++) begin
            fs = (i == 0 && fs_first) || ($urandom_range(99, 0) < fs_pct);
            send_word(pick_word(), fs);
        end
    endtask

    // sizes and phases
    initial begin
        int i;
        int fs_pct;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = yrdo_pkg::CFG_FRAME_WIDTH;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_yuyv_word   = '0;
        s_frame_start = 1'b0;
        tx_gap_max    = 0;
        rx_gap_max    = 0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        rx_hold       = 1'b0;
        items_sent    = 0;
        settings_used = 0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset sizes (720 x 480), no frame start
        run_frames(40, 1'b0, 0);

        // corner pixels on a 4 x 12 frame: marker, sample and cyan lines,
        // then a frame start on the last word of the frame
        drain();
        write_sizes(11'd4, 11'd12);
        for (i = 0; i < 24; i++) send_word(directed_word(i), i == 0 || i == 23);

        // full-width window: samples 1 and 79 painted; odd width register
        drain();
        write_sizes(11'd159, 11'd8);
        run_frames(553, 1'b1, 0);
        // taller frame moves the sample line down; sample count wraps past 127
        drain();
        write_sizes(11'd159, 11'd12);
        run_frames(158, 1'b0, 0);

        // widest line, smallest height; long result hold-off fills the block
        drain();
        write_sizes(11'd2047, 11'd1);
        hold_req = 1'b1;
        run_frames(200, 1'b1, 0);

        // narrowest line, tallest frame; counters wrap from the old width
        drain();
        write_sizes(11'd0, 11'd2047);
        run_frames(60, 1'b0, 0);

        // odd center: no samples or marks
        drain();
        write_sizes(11'd6, 11'd10);
        run_frames(60, 1'b1, 0);

        // shrink in mid-frame
        drain();
        write_sizes(11'd40, 11'd24);
        run_frames(150, 1'b1, 0);
        drain();
        write_sizes(11'd8, 11'd6);
        run_frames(60, 1'b0, 0);

        // exact maxima
        drain();
        write_sizes(11'd1024, 11'd1024);
        run_frames(30, 1'b1, 2);

        // random sizes, mostly clean frames with some stray frame starts
        while (items_sent < TARGET_ITEMS) begin
            drain();
            write_sizes(pick_width(), pick_height());
            case ($urandom_range(3, 0))
                0:       fs_pct = 2;
                1:       fs_pct = 10;
                default: fs_pct = 0;
            endcase
            run_frames($urandom_range(120, 20), $urandom_range(1, 0), fs_pct);
        end

        drain();
        $display("sent %0d YUYV beats across %0d frame-size settings",
                 items_sent, settings_used);
        $display("checked %0d RGB beats, %0d carrying intensity samples",
                 beats_checked, samples_checked);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("PASS yuyv_to_rgb_decimate_overlay");
        end else begin
            $display("FAIL yuyv_to_rgb_decimate_overlay");
        end
        $finish;
    end

endmodule
